/* rtl/roi_pf_pkg.sv */
// ----------------------------------------------------------------------------
// roi_pf_pkg: shared types and constants of the ROI plane-fit unit
// Item and result structs, mode and status codes, and the command that the
// front hands to the back through the queue.
// ----------------------------------------------------------------------------
package roi_pf_pkg;

	// Width of the exact fixed-point words used by the fit.
	localparam int BW   = 160;
	// Doubled centre coordinates, sized for the largest supported map.
	localparam int CW   = 16;
	localparam int SUMW = 56;
	localparam int CNTW = 25;

	typedef enum logic [1:0] {
		MODE_BEGIN   = 2'd0,
		MODE_SAMPLE  = 2'd1,
		MODE_END     = 2'd2,
		MODE_COMPUTE = 2'd3
	} mode_t;

	localparam logic [2:0] ST_FIT      = 3'd0;
	localparam logic [2:0] ST_DEGEN    = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FEW_ROIS = 3'd3;
	localparam logic [2:0] ST_FEW_PTS  = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		mode_t              mode;
		logic signed [15:0] roi_x;
		logic signed [15:0] roi_y;
		logic signed [15:0] roi_w;
		logic signed [15:0] roi_h;
		logic signed [31:0] height_sample;
		logic               sample_valid;
	} item_t;

	typedef struct packed {
		logic [31:0] deviation;
		logic [2:0]  status;
		logic [6:0]  points_used;
	} result_t;

	typedef struct packed {
		logic                   is_compute;
		logic                   empty_map;
		logic                   few_rois;
		logic signed [SUMW-1:0] sum;
		logic [CNTW-1:0]        count;
		logic [CW-1:0]          cx;
		logic [CW-1:0]          cy;
	} cmd_t;

	function automatic logic [BW-1:0] mag(input logic signed [BW-1:0] v);
		return v[BW-1] ? BW'(-v) : BW'(v);
	endfunction

endpackage

/* rtl/roi_pf_fifo.sv */
// ----------------------------------------------------------------------------
// roi_pf_fifo: two-entry command queue
// Decouples the sample front from the fit back so that each can stall alone.
// ----------------------------------------------------------------------------
module roi_pf_fifo import roi_pf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic empty,
	output logic full
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	cmd_t            entry_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign rdata = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= wdata;
	end

endmodule

/* rtl/roi_pf_front.sv */
// ----------------------------------------------------------------------------
// roi_pf_front: ROI header clamping and height accumulation
// Holds the image size registers, clamps each header, sums valid samples and
// posts end-of-ROI and compute commands to the queue.
// ----------------------------------------------------------------------------
module roi_pf_front import roi_pf_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  item_t       item,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	output logic        push,
	output cmd_t        cmd
);

	localparam logic [14:0] DIM_LIM = 15'(MAX_DIM);

	logic [12:0]            iw_q, ih_q;
	logic signed [SUMW-1:0] sum_q;
	logic [CNTW-1:0]        cnt_q;
	logic [CW-1:0]          cx_q, cy_q;
	logic                   skip_q;
	logic [15:0]            rois_q;

	logic [14:0]        wd, ht;
	logic signed [17:0] xs, ys, xe, ye, rx, ry, ex, ey, wd_s, ht_s;
	logic               roi_empty;

	always_comb begin
		wd   = ({2'b0, iw_q} < DIM_LIM) ? {2'b0, iw_q} : DIM_LIM;
		ht   = ({2'b0, ih_q} < DIM_LIM) ? {2'b0, ih_q} : DIM_LIM;
		wd_s = $signed({3'b0, wd});
		ht_s = $signed({3'b0, ht});
		xs   = 18'(item.roi_x);
		ys   = 18'(item.roi_y);
		xe   = xs + 18'(item.roi_w);
		ye   = ys + 18'(item.roi_h);
		rx   = (xs > 18'sd0) ? xs : 18'sd0;
		ry   = (ys > 18'sd0) ? ys : 18'sd0;
		ex   = (xe < wd_s) ? xe : wd_s;
		ey   = (ye < ht_s) ? ye : ht_s;
		roi_empty = (ex <= rx) || (ey <= ry);
	end

	always_comb begin
		cmd.is_compute = (item.mode == MODE_COMPUTE);
		cmd.empty_map  = (iw_q == '0) || (ih_q == '0);
		cmd.few_rois   = (rois_q < 16'd3);
		cmd.sum        = sum_q;
		cmd.count      = cnt_q;
		cmd.cx         = cx_q;
		cmd.cy         = cy_q;
		push = accept && ((item.mode == MODE_COMPUTE) ||
			(item.mode == MODE_END && !skip_q && cnt_q != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= '0;
			ih_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  iw_q <= cfg_data;
				CFG_IMAGE_HEIGHT: ih_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			skip_q <= 1'b0;
			rois_q <= '0;
		end else if (accept) begin
			unique case (item.mode)
				MODE_BEGIN: begin
					if (rois_q != 16'hFFFF) rois_q <= rois_q + 16'd1;
					sum_q  <= '0;
					cnt_q  <= '0;
					skip_q <= roi_empty;
					if (!roi_empty) begin
						cx_q <= CW'(rx + ex);
						cy_q <= CW'(ry + ey);
					end
				end
				MODE_SAMPLE: begin
					// Samples beyond the cap of 2^24 per ROI are ignored.
					if (!skip_q && item.sample_valid && !cnt_q[CNTW-1]) begin
						sum_q <= sum_q + SUMW'(item.height_sample);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				MODE_END: begin
					sum_q <= '0;
					cnt_q <= '0;
				end
				MODE_COMPUTE: begin
					sum_q  <= '0;
					cnt_q  <= '0;
					cx_q   <= '0;
					cy_q   <= '0;
					skip_q <= 1'b0;
					rois_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/roi_pf_mul.sv */
// ----------------------------------------------------------------------------
// roi_pf_mul: sequential wide signed multiplier
// Shift-and-add on magnitudes, one multiplier bit per cycle, stopping as soon
// as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module roi_pf_mul import roi_pf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [BW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic                 done,
	output logic signed [BW-1:0] p
);

	logic          run_q, done_q, neg_q;
	logic [BW-1:0] ma_q, mb_q, acc_q;
	logic signed [BW-1:0] p_q;

	assign done = done_q;
	assign p    = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && mb_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= mag(a);
			mb_q  <= mag(b);
			acc_q <= '0;
			neg_q <= a[BW-1] ^ b[BW-1];
		end else if (run_q) begin
			if (mb_q == '0) begin
				p_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
			end else begin
				if (mb_q[0]) acc_q <= acc_q + ma_q;
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end
		end
	end

endmodule

/* rtl/roi_pf_div.sv */
// ----------------------------------------------------------------------------
// roi_pf_div: restoring divider with a 32-bit quotient
// One quotient bit per cycle; the caller guarantees the quotient fits.
// ----------------------------------------------------------------------------
module roi_pf_div import roi_pf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [BW-1:0] dividend,
	input  logic [BW-1:0] divisor,
	output logic          done,
	output logic [31:0]   quotient
);

	logic          run_q, done_q;
	logic [4:0]    cnt_q;
	logic [BW-1:0] rem_q, d_q;
	logic [31:0]   q_q;
	logic          ge;

	assign ge       = (rem_q >= d_q);
	assign done     = done_q;
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd31;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			d_q   <= {divisor[BW-32:0], 31'b0};
			q_q   <= '0;
		end else if (run_q) begin
			if (ge) rem_q <= rem_q - d_q;
			d_q <= d_q >> 1;
			q_q <= {q_q[30:0], ge};
		end
	end

endmodule

/* rtl/roi_pf_back.sv */
// ----------------------------------------------------------------------------
// roi_pf_back: point store and least-squares plane fit
// Turns end commands into stored mean points and runs the exact plane fit,
// the degenerate fallback and the final scaling on compute commands.
// ----------------------------------------------------------------------------
module roi_pf_back import roi_pf_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_empty,
	input  cmd_t    cmd_head,
	output logic    cmd_pop,
	output logic    done,
	output result_t result
);

	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int DW  = 48;

	typedef struct packed {
		logic [CW-1:0]      x2;
		logic [CW-1:0]      y2;
		logic signed [31:0] z;
	} point_t;

	typedef enum logic [14:0] {
		B_IDLE     = 15'b000000000000001,
		B_MEAN     = 15'b000000000000010,
		B_CHECK    = 15'b000000000000100,
		B_SUM_RD   = 15'b000000000001000,
		B_SUM_MUL  = 15'b000000000010000,
		B_SUM_ACC  = 15'b000000000100000,
		B_MUL_GO   = 15'b000000001000000,
		B_MUL_WAIT = 15'b000000010000000,
		B_MM_RD    = 15'b000000100000000,
		B_MM_CMP   = 15'b000001000000000,
		B_RES_RD   = 15'b000010000000000,
		B_RES_MUL  = 15'b000100000000000,
		B_RES_CMP  = 15'b001000000000000,
		B_DIV_CHK  = 15'b010000000000000,
		B_DIV_WAIT = 15'b100000000000000
	} state_t;

	typedef enum logic [4:0] {
		OP_N, OP_SX, OP_SY, OP_SZ, OP_SXX, OP_SYY, OP_SXY, OP_SXZ, OP_SYZ,
		OP_PXX, OP_PYY, OP_PXY, OP_PXZ, OP_PYZ, OP_DP, OP_AN, OP_BN,
		OP_DX, OP_DY, OP_DZ
	} opnd_t;

	typedef enum logic [1:0] {ACT_LOAD, ACT_SUB, ACT_ABS} act_t;

	typedef enum logic [3:0] {
		DST_TMP, DST_PXX, DST_PYY, DST_PXY, DST_PXZ, DST_PYZ,
		DST_DP, DST_AN, DST_BN, DST_DEN
	} dst_t;

	typedef struct packed {
		opnd_t a;
		opnd_t b;
		act_t  act;
		dst_t  dst;
	} step_t;

	localparam logic [4:0] STEP_DP   = 5'd11;
	localparam logic [4:0] STEP_DEN  = 5'd16;
	localparam logic [4:0] STEP_RES  = 5'd17;
	localparam logic [4:0] STEP_LAST = 5'd19;

	function automatic step_t step_info(input logic [4:0] s);
		step_t r;
		r = '{OP_N, OP_N, ACT_LOAD, DST_TMP};
		unique case (s)
			5'd0:  r = '{OP_N,   OP_SXX, ACT_LOAD, DST_TMP};
			5'd1:  r = '{OP_SX,  OP_SX,  ACT_SUB,  DST_PXX};
			5'd2:  r = '{OP_N,   OP_SYY, ACT_LOAD, DST_TMP};
			5'd3:  r = '{OP_SY,  OP_SY,  ACT_SUB,  DST_PYY};
			5'd4:  r = '{OP_N,   OP_SXY, ACT_LOAD, DST_TMP};
			5'd5:  r = '{OP_SX,  OP_SY,  ACT_SUB,  DST_PXY};
			5'd6:  r = '{OP_N,   OP_SXZ, ACT_LOAD, DST_TMP};
			5'd7:  r = '{OP_SX,  OP_SZ,  ACT_SUB,  DST_PXZ};
			5'd8:  r = '{OP_N,   OP_SYZ, ACT_LOAD, DST_TMP};
			5'd9:  r = '{OP_SY,  OP_SZ,  ACT_SUB,  DST_PYZ};
			5'd10: r = '{OP_PXX, OP_PYY, ACT_LOAD, DST_TMP};
			5'd11: r = '{OP_PXY, OP_PXY, ACT_SUB,  DST_DP};
			5'd12: r = '{OP_PXZ, OP_PYY, ACT_LOAD, DST_TMP};
			5'd13: r = '{OP_PYZ, OP_PXY, ACT_SUB,  DST_AN};
			5'd14: r = '{OP_PYZ, OP_PXX, ACT_LOAD, DST_TMP};
			5'd15: r = '{OP_PXZ, OP_PXY, ACT_SUB,  DST_BN};
			5'd16: r = '{OP_DP,  OP_N,   ACT_ABS,  DST_DEN};
			5'd17: r = '{OP_DP,  OP_DZ,  ACT_LOAD, DST_TMP};
			5'd18: r = '{OP_AN,  OP_DX,  ACT_SUB,  DST_TMP};
			5'd19: r = '{OP_BN,  OP_DY,  ACT_SUB,  DST_TMP};
			default: ;
		endcase
		return r;
	endfunction

	state_t          state_q;
	logic [PCW-1:0]  pcount_q, idx_q, idx_nx;
	logic            ovf_q, done_q;
	logic [4:0]      step_q;
	cmd_t            cmd_q;
	result_t         result_q;

	point_t          mem [MAX_POINTS];
	point_t          rdata_q;
	point_t          new_pt;
	logic            mem_we;

	logic signed [31:0]   sx_q, sy_q;
	logic signed [47:0]   sxx_q, syy_q, sxy_q, sz_q;
	logic signed [63:0]   sxz_q, syz_q, xz_q, yz_q;
	logic [31:0]          xx_q, yy_q, xy_q;
	logic signed [DW-1:0] dx_q, dy_q, dz_q;
	logic signed [BW-1:0] tmp_q, pxx_q, pyy_q, pxy_q, pxz_q, pyz_q, dp_q, an_q, bn_q;
	logic [BW-1:0]        den_q, best_q;
	logic signed [31:0]   lo_q, hi_q, lo_n, hi_n;

	step_t                st;
	logic                 mul_start, mul_done, div_start, div_done;
	logic signed [BW-1:0] mul_a, mul_b, mul_p, v;
	logic [BW-1:0]        div_n, div_d;
	logic [31:0]          quot;
	logic [SUMW-1:0]      head_mag;
	logic                 last, sat;
	logic [PCW+6:0]       pc_ext;
	logic [6:0]           used;
	logic signed [16:0]   xs, ys;
	logic signed [PCW:0]  n_s;
	logic [BW-1:0]        tmp_mag;

	function automatic logic signed [BW-1:0] pick(input opnd_t s);
		logic signed [BW-1:0] r;
		r = '0;
		case (s)
			OP_N:    r = BW'(n_s);
			OP_SX:   r = BW'(sx_q);
			OP_SY:   r = BW'(sy_q);
			OP_SZ:   r = BW'(sz_q);
			OP_SXX:  r = BW'(sxx_q);
			OP_SYY:  r = BW'(syy_q);
			OP_SXY:  r = BW'(sxy_q);
			OP_SXZ:  r = BW'(sxz_q);
			OP_SYZ:  r = BW'(syz_q);
			OP_PXX:  r = pxx_q;
			OP_PYY:  r = pyy_q;
			OP_PXY:  r = pxy_q;
			OP_PXZ:  r = pxz_q;
			OP_PYZ:  r = pyz_q;
			OP_DP:   r = dp_q;
			OP_AN:   r = an_q;
			OP_BN:   r = bn_q;
			OP_DX:   r = BW'(dx_q);
			OP_DY:   r = BW'(dy_q);
			OP_DZ:   r = BW'(dz_q);
			default: r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		st       = step_info(step_q);
		mul_a    = pick(st.a);
		mul_b    = pick(st.b);
		n_s      = $signed({1'b0, pcount_q});
		xs       = $signed({1'b0, rdata_q.x2});
		ys       = $signed({1'b0, rdata_q.y2});
		idx_nx   = idx_q + 1'b1;
		last     = (idx_nx == pcount_q);
		pc_ext   = {7'b0, pcount_q};
		used     = pc_ext[6:0];
		tmp_mag  = mag(tmp_q);
		sat      = (best_q >= {den_q[BW-33:0], 32'b0});
		head_mag = cmd_head.sum[SUMW-1] ? SUMW'(-cmd_head.sum) : SUMW'(cmd_head.sum);
		case (st.act)
			ACT_LOAD: v = mul_p;
			ACT_SUB:  v = tmp_q - mul_p;
			ACT_ABS:  v = $signed(mag(mul_p));
			default:  v = mul_p;
		endcase
		if (idx_q == '0) begin
			lo_n = rdata_q.z;
			hi_n = rdata_q.z;
		end else begin
			lo_n = (rdata_q.z < lo_q) ? rdata_q.z : lo_q;
			hi_n = (rdata_q.z > hi_q) ? rdata_q.z : hi_q;
		end
	end

	assign cmd_pop   = (state_q == B_IDLE) && !cmd_empty;
	assign mul_start = (state_q == B_MUL_GO);
	assign div_start = (cmd_pop && !cmd_head.is_compute) || (state_q == B_DIV_CHK && !sat);
	assign div_n     = (state_q == B_IDLE) ? BW'(head_mag) : best_q;
	assign div_d     = (state_q == B_IDLE) ? BW'(cmd_head.count) : den_q;
	assign mem_we    = (state_q == B_MEAN) && div_done && (pcount_q < PCW'(MAX_POINTS));
	assign done      = done_q;
	assign result    = result_q;

	always_comb begin
		new_pt.x2 = cmd_q.cx;
		new_pt.y2 = cmd_q.cy;
		new_pt.z  = cmd_q.sum[SUMW-1] ? -$signed(quot) : $signed(quot);
	end

	roi_pf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	roi_pf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (mem_we) mem[pcount_q[AW-1:0]] <= new_pt;
		rdata_q <= mem[idx_q[AW-1:0]];
	end

	// Control: sequencing, point count and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			pcount_q <= '0;
			idx_q    <= '0;
			ovf_q    <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!cmd_empty) state_q <= cmd_head.is_compute ? B_CHECK : B_MEAN;
				end
				B_MEAN: begin
					if (div_done) begin
						if (pcount_q < PCW'(MAX_POINTS)) pcount_q <= pcount_q + 1'b1;
						else ovf_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				B_CHECK: begin
					if (cmd_q.empty_map || cmd_q.few_rois || pcount_q < PCW'(3)) begin
						done_q   <= 1'b1;
						pcount_q <= '0;
						ovf_q    <= 1'b0;
						state_q  <= B_IDLE;
					end else begin
						idx_q   <= '0;
						state_q <= B_SUM_RD;
					end
				end
				B_SUM_RD:  state_q <= B_SUM_MUL;
				B_SUM_MUL: state_q <= B_SUM_ACC;
				B_SUM_ACC: begin
					idx_q <= idx_nx;
					if (last) begin
						step_q  <= '0;
						state_q <= B_MUL_GO;
					end else begin
						state_q <= B_SUM_RD;
					end
				end
				B_MUL_GO: state_q <= B_MUL_WAIT;
				B_MUL_WAIT: begin
					if (mul_done) begin
						if (step_q == STEP_DP && v == '0) begin
							idx_q   <= '0;
							state_q <= B_MM_RD;
						end else if (step_q == STEP_DEN) begin
							idx_q   <= '0;
							state_q <= B_RES_RD;
						end else if (step_q == STEP_LAST) begin
							state_q <= B_RES_CMP;
						end else begin
							step_q  <= step_q + 5'd1;
							state_q <= B_MUL_GO;
						end
					end
				end
				B_MM_RD: state_q <= B_MM_CMP;
				B_MM_CMP: begin
					idx_q <= idx_nx;
					if (last) begin
						done_q   <= 1'b1;
						pcount_q <= '0;
						ovf_q    <= 1'b0;
						state_q  <= B_IDLE;
					end else begin
						state_q <= B_MM_RD;
					end
				end
				B_RES_RD: state_q <= B_RES_MUL;
				B_RES_MUL: begin
					step_q  <= STEP_RES;
					state_q <= B_MUL_GO;
				end
				B_RES_CMP: begin
					idx_q   <= idx_nx;
					state_q <= last ? B_DIV_CHK : B_RES_RD;
				end
				B_DIV_CHK: begin
					if (sat) begin
						done_q   <= 1'b1;
						pcount_q <= '0;
						ovf_q    <= 1'b0;
						state_q  <= B_IDLE;
					end else begin
						state_q <= B_DIV_WAIT;
					end
				end
				B_DIV_WAIT: begin
					if (div_done) begin
						done_q   <= 1'b1;
						pcount_q <= '0;
						ovf_q    <= 1'b0;
						state_q  <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Datapath: sums, fit terms and the result word.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!cmd_empty) cmd_q <= cmd_head;
			end
			B_CHECK: begin
				sx_q  <= '0;
				sy_q  <= '0;
				sz_q  <= '0;
				sxx_q <= '0;
				syy_q <= '0;
				sxy_q <= '0;
				sxz_q <= '0;
				syz_q <= '0;
				result_q.deviation   <= '0;
				result_q.points_used <= '0;
				if (cmd_q.empty_map) result_q.status <= ST_EMPTY;
				else if (cmd_q.few_rois) result_q.status <= ST_FEW_ROIS;
				else result_q.status <= ST_FEW_PTS;
			end
			B_SUM_MUL: begin
				xx_q <= 32'(rdata_q.x2) * 32'(rdata_q.x2);
				yy_q <= 32'(rdata_q.y2) * 32'(rdata_q.y2);
				xy_q <= 32'(rdata_q.x2) * 32'(rdata_q.y2);
				xz_q <= 64'(xs) * 64'(rdata_q.z);
				yz_q <= 64'(ys) * 64'(rdata_q.z);
			end
			B_SUM_ACC: begin
				sx_q  <= sx_q + 32'(xs);
				sy_q  <= sy_q + 32'(ys);
				sz_q  <= sz_q + 48'(rdata_q.z);
				sxx_q <= sxx_q + $signed({16'b0, xx_q});
				syy_q <= syy_q + $signed({16'b0, yy_q});
				sxy_q <= sxy_q + $signed({16'b0, xy_q});
				sxz_q <= sxz_q + xz_q;
				syz_q <= syz_q + yz_q;
			end
			B_MUL_WAIT: begin
				if (mul_done) begin
					case (st.dst)
						DST_TMP: tmp_q <= v;
						DST_PXX: pxx_q <= v;
						DST_PYY: pyy_q <= v;
						DST_PXY: pxy_q <= v;
						DST_PXZ: pxz_q <= v;
						DST_PYZ: pyz_q <= v;
						DST_DP:  dp_q  <= v;
						DST_AN:  an_q  <= v;
						DST_BN:  bn_q  <= v;
						DST_DEN: den_q <= BW'(v);
						default: ;
					endcase
					if (step_q == STEP_DEN) best_q <= '0;
				end
			end
			B_MM_CMP: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
				result_q.deviation   <= 32'(hi_n - lo_n);
				result_q.status      <= ovf_q ? ST_OVERFLOW : ST_DEGEN;
				result_q.points_used <= used;
			end
			B_RES_MUL: begin
				dz_q <= DW'(n_s) * DW'(rdata_q.z) - DW'(sz_q);
				dx_q <= DW'(n_s) * DW'(xs) - DW'(sx_q);
				dy_q <= DW'(n_s) * DW'(ys) - DW'(sy_q);
			end
			B_RES_CMP: begin
				if (tmp_mag > best_q) best_q <= tmp_mag;
			end
			B_DIV_CHK: begin
				result_q.deviation   <= 32'hFFFF_FFFF;
				result_q.status      <= ovf_q ? ST_OVERFLOW : ST_FIT;
				result_q.points_used <= used;
			end
			B_DIV_WAIT: begin
				if (div_done) result_q.deviation <= quot;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_pcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= PCW'(MAX_POINTS))
		else $error("point count exceeds the store depth");
	a_strobe_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == B_IDLE && pcount_q == '0 && !ovf_q))
		else $error("result issued without clearing the batch");
	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == B_MUL_WAIT)
		else $error("multiplier finished outside its wait state");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == B_MEAN || state_q == B_DIV_WAIT))
		else $error("divider finished outside its wait states");
`endif

endmodule

/* rtl/roi_plane_fit_coplanarity_unit.sv */
// ----------------------------------------------------------------------------
// roi_plane_fit_coplanarity_unit: ROI plane fit with maximum deviation
// Items are accepted on a rising edge with start high and busy low. Begin
// and sample items are absorbed by the front as they are accepted, so a
// pixel stream runs at one sample per cycle while busy stays low. Compute
// items, and end items of a ROI that kept samples, go into a two-entry
// command queue; busy is high only while that queue is full. An end item
// occupies the back while the shared divider forms the ROI mean, one
// quotient bit per cycle. A compute item reads each stored point for the
// sums (read, multiply, accumulate), forms seventeen wide products on the
// shift-add multiplier (one multiplier bit per cycle; twelve, then a scan
// of the heights, when the fit is degenerate), then per point three such
// products, the saturation check and the divide; error statuses skip the fit.
// The result appears on result for exactly one cycle with done high; the
// receiver always takes it. Configuration writes via cfg_we, cfg_index and
// cfg_data land at once. Reset clears the batch, the point count and both
// image size registers; the point store itself needs no clearing.
// ----------------------------------------------------------------------------
module roi_plane_fit_coplanarity_unit import roi_pf_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_DIM    = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	logic accept, push, pop, empty, full;
	cmd_t cmd_in, cmd_head;

	assign busy   = full;
	assign accept = start && !busy;

	roi_pf_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.cmd       (cmd_in)
	);

	roi_pf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.pop    (pop),
		.rdata  (cmd_head),
		.empty  (empty),
		.full   (full)
	);

	roi_pf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (pop),
		.done      (done),
		.result    (result)
	);

endmodule

/* tb/sv/roi_plane_fit_coplanarity_unit_tb.sv */
// ----------------------------------------------------------------------------
// roi_plane_fit_coplanarity_unit_tb: self-checking bench of the ROI plane fit
// A directed table of ROI batches, then random batches under several image
// sizes, with results predicted by an exact wide-integer plane fit and
// compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module roi_plane_fit_coplanarity_unit_tb;
	import roi_pf_pkg::*;

	localparam int  NPTS      = 64;
	localparam int  DIM_MAX   = 4096;
	localparam int  SETTLE    = 300;
	localparam longint LIMIT  = 4000000;

	typedef logic signed [255:0] wide_t;
	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    done;
	result_t result;
	logic    cfg_we = 1'b0;
	logic    cfg_index = CFG_IMAGE_WIDTH;
	logic [12:0] cfg_data = '0;

	// Shadow state of the unit.
	longint  img_w, img_h;
	longint  pt_x[NPTS], pt_y[NPTS], pt_z[NPTS];
	longint  acc_sum, cen_x, cen_y;
	int      acc_cnt, roi_cnt, pt_cnt;
	bit      skip_roi, lost_point;

	result_t dev_q[$];
	int      errors = 0;
	int      items_sent = 0;
	bit      idling = 1'b1;
	longint  cycles = 0;

	roi_plane_fit_coplanarity_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("roi_plane_fit_coplanarity_unit verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && done) begin
			if (dev_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				if (result.deviation !== dev_q[0].deviation)
					$display("%0t: deviation expected %h actual %h", $time,
						dev_q[0].deviation, result.deviation);
				if (result.status !== dev_q[0].status)
					$display("%0t: status expected %0d actual %0d", $time,
						dev_q[0].status, result.status);
				if (result.points_used !== dev_q[0].points_used)
					$display("%0t: points_used expected %0d actual %0d", $time,
						dev_q[0].points_used, result.points_used);
				if (result !== dev_q[0])
					errors++;
				void'(dev_q.pop_front());
			end
		end
	end

	function automatic void clear_batch();
		acc_sum = 0; acc_cnt = 0; cen_x = 0; cen_y = 0;
		skip_roi = 0; roi_cnt = 0; pt_cnt = 0; lost_point = 0;
	endfunction

	function automatic wide_t w(longint v);
		return wide_t'(v);
	endfunction

	// Exact least-squares fit over the stored means, as the unit computes it.
	function automatic result_t plane_deviation();
		result_t r;
		longint n, sx, sy, sz, sxx, syy, sxy, sxz, syz, lo, hi;
		wide_t pxx, pyy, pxy, pxz, pyz, dp, an, bn, num;
		logic [255:0] den, best, lim, q;
		r = '0;
		n = pt_cnt;
		sx = 0; sy = 0; sz = 0; sxx = 0; syy = 0; sxy = 0; sxz = 0; syz = 0;
		if (img_w == 0 || img_h == 0) begin
			r.status = ST_EMPTY;
			return r;
		end
		if (roi_cnt < 3) begin
			r.status = ST_FEW_ROIS;
			return r;
		end
		if (pt_cnt < 3) begin
			r.status = ST_FEW_PTS;
			return r;
		end
		r.points_used = 7'(pt_cnt);
		for (int i = 0; i < pt_cnt; i++) begin
			sx += pt_x[i]; sy += pt_y[i]; sz += pt_z[i];
			sxx += pt_x[i] * pt_x[i]; syy += pt_y[i] * pt_y[i];
			sxy += pt_x[i] * pt_y[i];
			sxz += pt_x[i] * pt_z[i]; syz += pt_y[i] * pt_z[i];
		end
		pxx = w(n) * w(sxx) - w(sx) * w(sx);
		pyy = w(n) * w(syy) - w(sy) * w(sy);
		pxy = w(n) * w(sxy) - w(sx) * w(sy);
		pxz = w(n) * w(sxz) - w(sx) * w(sz);
		pyz = w(n) * w(syz) - w(sy) * w(sz);
		dp = pxx * pyy - pxy * pxy;
		if (dp == 0) begin
			lo = pt_z[0]; hi = pt_z[0];
			for (int i = 1; i < pt_cnt; i++) begin
				if (pt_z[i] < lo) lo = pt_z[i];
				if (pt_z[i] > hi) hi = pt_z[i];
			end
			r.deviation = 32'(hi - lo);
			r.status = lost_point ? ST_OVERFLOW : ST_DEGEN;
			return r;
		end
		r.status = lost_point ? ST_OVERFLOW : ST_FIT;
		an = pxz * pyy - pyz * pxy;
		bn = pyz * pxx - pxz * pxy;
		num = dp * w(n);
		den = num[255] ? -num : num;
		best = '0;
		for (int i = 0; i < pt_cnt; i++) begin
			num = dp * w(n * pt_z[i] - sz) - an * w(n * pt_x[i] - sx)
				- bn * w(n * pt_y[i] - sy);
			if (num[255])
				num = -num;
			if (256'(num) > best)
				best = num;
		end
		lim = den << 32;
		if (best >= lim) begin
			r.deviation = '1;
		end else begin
			q = best / den;
			r.deviation = q[31:0];
		end
		return r;
	endfunction

	// Advances the shadow state by one accepted item; returns 1 for a result.
	function automatic bit absorb(item_t it, output result_t r);
		longint wd, ht, rx, ry, ex, ey;
		r = '0;
		case (it.mode)
			MODE_BEGIN: begin
				wd = (img_w < DIM_MAX) ? img_w : DIM_MAX;
				ht = (img_h < DIM_MAX) ? img_h : DIM_MAX;
				rx = (it.roi_x > 0) ? longint'(it.roi_x) : 0;
				ry = (it.roi_y > 0) ? longint'(it.roi_y) : 0;
				ex = longint'(it.roi_x) + longint'(it.roi_w);
				ey = longint'(it.roi_y) + longint'(it.roi_h);
				if (ex > wd) ex = wd;
				if (ey > ht) ey = ht;
				if (roi_cnt < 65535) roi_cnt++;
				acc_sum = 0; acc_cnt = 0;
				if (ex - rx <= 0 || ey - ry <= 0) begin
					skip_roi = 1;
				end else begin
					skip_roi = 0;
					cen_x = rx + ex;
					cen_y = ry + ey;
				end
			end
			MODE_SAMPLE: begin
				if (!skip_roi && it.sample_valid && acc_cnt < (1 << 24)) begin
					acc_sum += longint'(it.height_sample);
					acc_cnt++;
				end
			end
			MODE_END: begin
				if (!skip_roi && acc_cnt > 0) begin
					if (pt_cnt < NPTS) begin
						pt_x[pt_cnt] = cen_x;
						pt_y[pt_cnt] = cen_y;
						pt_z[pt_cnt] = acc_sum / longint'(acc_cnt);
						pt_cnt++;
					end else begin
						lost_point = 1;
					end
				end
				acc_sum = 0; acc_cnt = 0;
			end
			default: begin
				r = plane_deviation();
				clear_batch();
				return 1;
			end
		endcase
		return 0;
	endfunction

	function automatic item_t mk(mode_t m, int x, int y, int wv, int hv,
			int hs, bit v);
		item_t it;
		it.mode = m;
		it.roi_x = 16'(x); it.roi_y = 16'(y);
		it.roi_w = 16'(wv); it.roi_h = 16'(hv);
		it.height_sample = 32'(hs);
		it.sample_valid = v;
		return it;
	endfunction

	// Called at a rising edge; returns at the edge where the transfer happens.
	task automatic xfer(input item_t it, input bit typed, input result_t tr);
		result_t r;
		if (idling && $urandom_range(0, 99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		items_sent++;
		if (absorb(it, r))
			dev_q = {dev_q, typed ? tr : r};
	endtask

	task automatic send(input item_t it);
		xfer(it, 1'b0, '0);
	endtask

	// Waits until the unit has drained, including ROI ends still in flight.
	task automatic drain();
		start <= 1'b0;
		while (dev_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_image(input int wv, input int hv);
		cfg_we <= 1'b1; cfg_index <= CFG_IMAGE_WIDTH; cfg_data <= 13'(wv);
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT; cfg_data <= 13'(hv);
		@(posedge clk);
		cfg_we <= 1'b0;
		img_w = wv & 13'h1FFF;
		img_h = hv & 13'h1FFF;
	endtask

	function automatic int rnd_sample();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return int'($urandom_range(0, 1 << 24));
		endcase
	endfunction

	// One batch of ROIs followed by a compute; a few items are noise.
	task automatic random_batch(input int nroi);
		item_t it;
		int wd, ht;
		logic [127:0] raw;
		wd = (img_w < DIM_MAX) ? int'(img_w) : DIM_MAX;
		ht = (img_h < DIM_MAX) ? int'(img_h) : DIM_MAX;
		for (int k = 0; k < nroi; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				raw = {$urandom, $urandom, $urandom, $urandom};
				it = raw[$bits(item_t)-1:0];
				send(it);
			end
			if ($urandom_range(0, 7) == 0)
				it = mk(MODE_BEGIN, $urandom, $urandom, $urandom, $urandom, 0, 0);
			else
				it = mk(MODE_BEGIN, int'($urandom_range(0, wd + 20)) - 10,
					int'($urandom_range(0, ht + 20)) - 10,
					int'($urandom_range(0, 80)) - 4,
					int'($urandom_range(0, 80)) - 4, 0, 0);
			send(it);
			repeat ($urandom_range(0, 4))
				send(mk(MODE_SAMPLE, $urandom, $urandom, $urandom, $urandom,
					rnd_sample(), $urandom_range(0, 9) != 0));
			send(mk(MODE_END, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom));
		end
		send(mk(MODE_COMPUTE, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom));
	endtask

	initial begin
		row_t rows[$];
		row_t rw;
		int phase;
		clear_batch();
		img_w = 0; img_h = 0;
		for (int i = 0; i < NPTS; i++) begin
			pt_x[i] = 0; pt_y[i] = 0; pt_z[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight after reset the map is empty.
		xfer(mk(MODE_COMPUTE, 0, 0, 0, 0, 0, 0), 1'b1, '{0, ST_EMPTY, 0});
		drain();
		set_image(4096, 4096);

		rw.typed = 1; rw.res = '{0, ST_FEW_ROIS, 0};
		rw.it = mk(MODE_COMPUTE, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.typed = 0;
		// Full-scale heights and an invalid sample in one ROI.
		rw.it = mk(MODE_BEGIN, 0, 0, 10, 10, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, 32'h7FFFFFFF, 1); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, 32'h80000000, 1); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, -1, -1, -1, -1, -1, 0); rows = {rows, rw};
		rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_BEGIN, 100, 50, 20, 30, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, 32'h10000, 1); rows = {rows, rw};
		rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		// A ROI that clamps to nothing swallows its samples and end.
		rw.it = mk(MODE_BEGIN, -32768, -32768, 32767, 32767, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, 1234, 1); rows = {rows, rw};
		rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_BEGIN, 4090, 4090, 32767, 32767, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, -5, 1); rows = {rows, rw};
		rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		// Samples after an end start a fresh mean at the same centre.
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, 7, 1); rows = {rows, rw};
		rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_BEGIN, 10, 10, 4, 4, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, 99, 0); rows = {rows, rw};
		rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_COMPUTE, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		// Two points from three ROIs.
		rw.it = mk(MODE_BEGIN, 0, 0, 2, 2, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, 1, 1); rows = {rows, rw};
		rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, 3, 1); rows = {rows, rw};
		rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_BEGIN, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.it = mk(MODE_BEGIN, 5, 5, -3, 2, 0, 0); rows = {rows, rw};
		rw.typed = 1; rw.res = '{0, ST_FEW_PTS, 0};
		rw.it = mk(MODE_COMPUTE, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		rw.typed = 0;
		// Three points at one centre leave the fit degenerate.
		for (int k = 0; k < 3; k++) begin
			rw.it = mk(MODE_BEGIN, 3, 3, 2, 2, 0, 0); rows = {rows, rw};
			rw.it = mk(MODE_SAMPLE, 0, 0, 0, 0, k * 1000 - 7, 1); rows = {rows, rw};
			rw.it = mk(MODE_END, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		end
		rw.it = mk(MODE_COMPUTE, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
		foreach (rows[i])
			xfer(rows[i].it, rows[i].typed, rows[i].res);

		phase = 0;
		while (items_sent < 1050) begin
			if (items_sent % 97 < 4 || phase == 0) begin
				// The sender holds off here until the unit has drained.
				drain();
				case (phase % 6)
					0: set_image(4096, 4096);
					1: set_image(8191, 8191);
					2: set_image(1, 1);
					3: set_image(0, $urandom_range(1, 8191));
					4: set_image(40, 30);
					default: set_image($urandom_range(0, 8191), $urandom_range(0, 8191));
				endcase
				if (phase == 1) begin
					// Store overflow: more points than the store holds.
					for (int k = 0; k < NPTS + 2; k++) begin
						send(mk(MODE_BEGIN, $urandom_range(0, 200), $urandom_range(0, 200),
							$urandom_range(1, 9), $urandom_range(1, 9), 0, 0));
						send(mk(MODE_SAMPLE, 0, 0, 0, 0, rnd_sample(), 1));
						send(mk(MODE_END, 0, 0, 0, 0, 0, 0));
					end
					send(mk(MODE_COMPUTE, 0, 0, 0, 0, 0, 0));
				end
				phase++;
			end
			idling = !(items_sent > 400 && items_sent < 600);
			random_batch($urandom_range(0, 9));
		end

		start <= 1'b0;
		while (dev_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("roi_plane_fit_coplanarity_unit verification clean");
		else
			$display("roi_plane_fit_coplanarity_unit verification failed");
		$finish;
	end

endmodule
